@@ hdl/udp_header_validator_crc32_assert.svh @@
// assertion macros for the datagram header validator
`ifndef UDP_HEADER_VALIDATOR_CRC32_ASSERT_SVH
`define UDP_HEADER_VALIDATOR_CRC32_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define UDPHV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("udphv: same-cycle check failed");
// next-cycle implication
`define UDPHV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("udphv: next-cycle check failed");
`else
`define UDPHV_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define UDPHV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/udphv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udphv_pkg
// types, constants and the crc-32 byte update for the header validator
// ----------------------------------------------------------------------------
package udphv_pkg;

    // largest datagram that is counted, and the byte counter width
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int COUNT_W          = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [15:0] VERSION_RESET = 16'd1001;
    localparam logic [16:0] LEN_EXTRA = 17'd16;
    localparam int          HDR_BYTES = 20;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_MAGIC    = 3'd2;
    localparam logic [2:0] ST_VERSION  = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_CRC      = 3'd5;

    // register index of expected_version
    localparam logic REG_VERSION = 1'b0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] client_id;
        logic [31:0] message_type;
        logic [16:0] packet_length;
    } t_out_item;

    // magic "DSUC", byte by byte
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h44;
            2'd1:    m = 8'h53;
            2'd2:    m = 8'h55;
            default: m = 8'h43;
        endcase
        return m;
    endfunction

    // reflected crc-32 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

@@ hdl/udp_header_validator_crc32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_header_validator_crc32
// checks a received datagram header and crc-32, one byte per transaction
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------
//   input    | in        | i_valid / o_stall      | i_data  (rx_byte, last_byte)
//   result   | out       | o_valid / i_stall      | o_data  (status, ids, length)
//   config   | in        | apb psel/penable/pready| expected_version at 0x0
//
// one byte per cycle unless a final byte waits, each held in the input register
// the crc xor network and checks settle before the next edge loads the result
// a final byte passes the input register, then the result register onto o_data
// synchronous active-low reset clears the datagram state, expected_version 1001
// only a final byte waits on a stalled result slot, and while it waits the
// input is stalled; other bytes keep flowing
// ----------------------------------------------------------------------------
`include "udp_header_validator_crc32_assert.svh"

module udp_header_validator_crc32 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  udphv_pkg::t_in_item   i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output udphv_pkg::t_out_item  o_data,
    input  logic                  i_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import udphv_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       out_free;
    logic       proc_fire;
    logic       in_take;
    logic [15:0] expected_version;
    t_out_item  result;

    // configuration register
    udphv_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_expected_version (expected_version)
    );

    // flow control: a final byte needs a free result slot
    assign out_free  = !r_out_valid || !i_stall;
    assign proc_fire = r_in_valid && (!r_in.last_byte || out_free);
    assign in_take   = !r_in_valid || proc_fire;
    assign o_stall   = !in_take;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_valid) begin
            r_in <= i_data;
        end
    end

    // header parser and crc
    udphv_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (proc_fire),
        .i_item             (r_in),
        .i_expected_version (expected_version),
        .o_result           (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_fire && r_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && proc_fire && r_in.last_byte) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    `UDPHV_ASSERT_IMPLY(a_ids_only_ok, i_clk, i_rst_n, o_valid && (o_data.status != ST_OK),
        (o_data.client_id == 32'd0) && (o_data.message_type == 32'd0))
    `UDPHV_ASSERT_IMPLY(a_status_range, i_clk, i_rst_n, o_valid, o_data.status <= ST_CRC)
    `UDPHV_ASSERT_NEXT(a_final_gives_result, i_clk, i_rst_n, proc_fire && r_in.last_byte, o_valid)
    `UDPHV_ASSERT_IMPLY(a_stall_needs_byte, i_clk, i_rst_n, o_stall, r_in_valid && r_in.last_byte)

endmodule

@@ hdl/udphv_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udphv_cfg
// apb register holding the expected protocol version
// ----------------------------------------------------------------------------
module udphv_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_expected_version
);
    import udphv_pkg::*;

    logic [15:0] r_version;

    assign pready = 1'b1;

    // register write in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VERSION_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_VERSION)) begin
            r_version <= pwdata[15:0];
        end
    end

    // read back
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_VERSION) begin
            prdata = {16'd0, r_version};
        end
    end

    assign o_expected_version = r_version;

endmodule

@@ hdl/udphv_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udphv_parser
// per-byte header capture and crc update, status on the final byte
// ----------------------------------------------------------------------------
module udphv_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  udphv_pkg::t_in_item   i_item,
    input  logic [15:0]           i_expected_version,
    output udphv_pkg::t_out_item  o_result
);
    import udphv_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [31:0]        r_crc, n_crc;
    logic               r_magic_ok, n_magic_ok;
    logic [15:0]        r_version, n_version;
    logic [15:0]        r_decl, n_decl;
    logic [31:0]        r_rx_crc, n_rx_crc;
    logic [31:0]        r_client, n_client;
    logic [31:0]        r_type, n_type;

    logic        full;
    logic [16:0] eff_len;
    logic [7:0]  b;

    assign b    = i_item.rx_byte;
    assign full = (r_count >= COUNT_W'(MAX_PACKET_BYTES));

    // field capture and crc update for the current byte
    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_magic_ok = r_magic_ok;
        n_version  = r_version;
        n_decl     = r_decl;
        n_rx_crc   = r_rx_crc;
        n_client   = r_client;
        n_type     = r_type;
        if (!full) begin
            if (r_count < COUNT_W'(4)) begin
                if (b != magic_byte(r_count[1:0])) begin
                    n_magic_ok = 1'b0;
                end
            end else if (r_count < COUNT_W'(6)) begin
                n_version[8*r_count[0] +: 8] = b;
            end else if (r_count < COUNT_W'(8)) begin
                n_decl[8*r_count[0] +: 8] = b;
            end else if (r_count < COUNT_W'(12)) begin
                n_rx_crc[8*r_count[1:0] +: 8] = b;
            end else if (r_count < COUNT_W'(16)) begin
                n_client[8*r_count[1:0] +: 8] = b;
            end else if (r_count < COUNT_W'(HDR_BYTES)) begin
                n_type[8*r_count[1:0] +: 8] = b;
            end
            // crc field bytes count as zero, bytes past the declared length plus 16 are skipped
            if ((r_count < COUNT_W'(8)) ||
                (17'(r_count) < ({1'b0, r_decl} + LEN_EXTRA))) begin
                if ((r_count >= COUNT_W'(8)) && (r_count < COUNT_W'(12))) begin
                    n_crc = crc_byte(r_crc, 8'd0);
                end else begin
                    n_crc = crc_byte(r_crc, b);
                end
            end
            n_count = r_count + COUNT_W'(1);
        end
    end

    // result for a final byte, in check order
    assign eff_len = {1'b0, n_decl} + LEN_EXTRA;

    always_comb begin
        o_result.status        = ST_OK;
        o_result.client_id     = 32'd0;
        o_result.message_type  = 32'd0;
        o_result.packet_length = 17'(n_count);
        if (n_count < COUNT_W'(HDR_BYTES)) begin
            o_result.status = ST_SHORT;
        end else if (!n_magic_ok) begin
            o_result.status = ST_MAGIC;
        end else if (n_version != i_expected_version) begin
            o_result.status = ST_VERSION;
        end else if (eff_len > 17'(n_count)) begin
            o_result.status = ST_TRUNC;
        end else begin
            o_result.packet_length = eff_len;
            if (n_rx_crc != ~n_crc) begin
                o_result.status = ST_CRC;
            end else begin
                o_result.client_id    = n_client;
                o_result.message_type = n_type;
            end
        end
    end

    // datagram state, cleared after each final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_magic_ok <= 1'b1;
            r_version  <= 16'd0;
            r_decl     <= 16'd0;
            r_rx_crc   <= 32'd0;
            r_client   <= 32'd0;
            r_type     <= 32'd0;
        end else if (i_fire) begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_magic_ok <= n_magic_ok;
            r_version  <= n_version;
            r_decl     <= n_decl;
            r_rx_crc   <= n_rx_crc;
            r_client   <= n_client;
            r_type     <= n_type;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// datagram header and crc-32 validator: byte stream in, one verdict per datagram
//
// well-formed datagrams with random content, each header fault, truncation,
// an oversize frame and raw noise, streamed with random bursts and gaps
// while the result side stalls on its own pattern; a scoreboard predicts each
// verdict from the accepted bytes and compares it field by field; the expected
// version register runs at reset value, both extremes and a random value,
// with a long result-side hold-off in the last phase
// ----------------------------------------------------------------------------
module testbench;
    import udphv_pkg::*;

    localparam logic [31:0] DGRAM_MAGIC  = "DSUC";
    localparam logic [2:0]  VERSION_ADDR = {REG_VERSION, 2'b00};
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned END_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef enum int {
        DG_GOOD, DG_BAD_CRC, DG_SHORT, DG_BAD_MAGIC, DG_BAD_VERSION, DG_TRUNCATED, DG_NOISE
    } t_dg_kind;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in_item    i_data  = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_data;
    logic        i_stall = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // reflected crc-32, one byte, bit-serial
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        return r;
    endfunction

    // predicts one verdict per datagram and holds those still owed by the block
    class t_verdict_board;
        logic [15:0] want_version;
        int unsigned byte_idx;
        logic [31:0] crc_run;
        bit          magic_seen_ok;
        logic [15:0] ver_field;
        logic [15:0] len_field;
        logic [31:0] crc_field;
        logic [31:0] client_field;
        logic [31:0] type_field;
        t_out_item   due_verdicts[$];
        int unsigned frames_noted;
        int unsigned errors;

        function new();
            want_version = VERSION_RESET;
            frames_noted = 0;
            errors       = 0;
            restart();
        endfunction

        function void restart();
            byte_idx      = 0;
            crc_run       = CRC_INIT;
            magic_seen_ok = 1'b1;
            ver_field     = '0;
            len_field     = '0;
            crc_field     = '0;
            client_field  = '0;
            type_field    = '0;
        endfunction

        function void report_mismatch(input string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // one accepted byte transaction
        function void take_byte(input t_in_item it);
            logic [7:0]  b;
            logic [16:0] eff;
            t_out_item   v;
            b = it.rx_byte;
            // bytes past the size limit update nothing
            if (byte_idx < MAX_PACKET_BYTES) begin
                if (byte_idx < 4) begin
                    if (b != DGRAM_MAGIC[31 - 8*byte_idx -: 8]) magic_seen_ok = 1'b0;
                end else if (byte_idx < 6) begin
                    ver_field[8*(byte_idx-4) +: 8] = b;
                end else if (byte_idx < 8) begin
                    len_field[8*(byte_idx-6) +: 8] = b;
                end else if (byte_idx < 12) begin
                    crc_field[8*(byte_idx-8) +: 8] = b;
                end else if (byte_idx < 16) begin
                    client_field[8*(byte_idx-12) +: 8] = b;
                end else if (byte_idx < HDR_BYTES) begin
                    type_field[8*(byte_idx-16) +: 8] = b;
                end
                // crc field counts as zero, bytes past the declared length plus 16 are left out
                if (byte_idx < 8 || byte_idx < len_field + 16)
                    crc_run = crc_step(crc_run, (byte_idx >= 8 && byte_idx < 12) ? 8'h00 : b);
                byte_idx++;
            end
            if (!it.last_byte) return;

            // verdict on the final byte, checks in priority order
            eff = {1'b0, len_field} + LEN_EXTRA;
            v = '0;
            v.packet_length = 17'(byte_idx);
            if (byte_idx < HDR_BYTES) begin
                v.status = ST_SHORT;
            end else if (!magic_seen_ok) begin
                v.status = ST_MAGIC;
            end else if (ver_field != want_version) begin
                v.status = ST_VERSION;
            end else if (eff > byte_idx) begin
                v.status = ST_TRUNC;
            end else begin
                v.packet_length = eff;
                if (crc_field != ~crc_run) begin
                    v.status = ST_CRC;
                end else begin
                    v.status       = ST_OK;
                    v.client_id    = client_field;
                    v.message_type = type_field;
                end
            end
            due_verdicts = {due_verdicts, v};
            frames_noted++;
            restart();
        endfunction

        // one accepted result transaction
        function void match_result(input t_out_item got);
            t_out_item want;
            if (due_verdicts.size() == 0) begin
                report_mismatch($sformatf("result with none pending: status %0d length %0d",
                                          got.status, got.packet_length));
                return;
            end
            want = due_verdicts.pop_front();
            if (got.status !== want.status || got.client_id !== want.client_id ||
                got.message_type !== want.message_type ||
                got.packet_length !== want.packet_length)
                report_mismatch($sformatf(
                    "exp status %0d client %h type %h length %0d / got %0d %h %h %0d",
                    want.status, want.client_id, want.message_type, want.packet_length,
                    got.status, got.client_id, got.message_type, got.packet_length));
        endfunction
    endclass

    t_verdict_board board = new();

    logic [15:0] cur_version    = VERSION_RESET;
    int unsigned accepted_bytes = 0;
    int unsigned burst_left     = 0;
    bit          hold_request   = 1'b0;

    udp_header_validator_crc32 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // observe both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.take_byte(i_data);
            if (o_valid && !i_stall) board.match_result(o_data);
        end
    end

    // result-side stall pattern, with one long hold-off on request
    initial begin : receiver
        int unsigned hold_left = 0;
        int unsigned mode_left = 0;
        bit          hold_taken = 1'b0;
        t_rx_mode    mode = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_OPEN:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
                    default:  i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // run limit
    initial begin : watchdog
        int unsigned cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // offer one byte, idling between bursts, and hold it until accepted
    task automatic push_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= '{rx_byte: b, last_byte: fin};
        do @(posedge i_clk); while (o_stall);
        accepted_bytes++;
    endtask

    // span: trailing bytes for header kinds, total length for short, truncated and noise
    task automatic send_datagram(input t_dg_kind kind, input int unsigned declared,
                                 input int unsigned span, input logic [31:0] client,
                                 input logic [31:0] mtype);
        logic [7:0]  frame[$];
        logic [7:0]  head[20];
        logic [15:0] ver;
        logic [31:0] crc;
        int unsigned eff;
        int unsigned total;
        int unsigned k;
        eff = declared + 16;
        ver = (kind == DG_BAD_VERSION) ? cur_version ^ 16'($urandom_range(1, 65535))
                                       : cur_version;
        case (kind)
            DG_SHORT, DG_TRUNCATED, DG_NOISE: total = span;
            default: total = ((eff > 20) ? eff : 20) + span;
        endcase
        // little-endian header
        for (k = 0; k < 4; k++) head[k] = DGRAM_MAGIC[31 - 8*k -: 8];
        head[4] = ver[7:0];
        head[5] = ver[15:8];
        head[6] = declared[7:0];
        head[7] = declared[15:8];
        for (k = 8; k < 12; k++) head[k] = 8'h00;
        for (k = 0; k < 4; k++) begin
            head[12+k] = client[8*k +: 8];
            head[16+k] = mtype[8*k +: 8];
        end
        for (k = 0; k < total; k++)
            frame = {frame, (kind != DG_NOISE && k < 20) ? head[k]
                                                         : 8'($urandom_range(0, 255))};
        // crc over the effective length with the crc field zeroed
        crc = CRC_INIT;
        for (k = 0; k < eff && k < total; k++)
            crc = crc_step(crc, (k >= 8 && k < 12) ? 8'h00 : frame[k]);
        crc = ~crc;
        if (kind == DG_BAD_CRC) crc ^= 32'h1 << $urandom_range(0, 31);
        if (kind != DG_NOISE)
            for (k = 8; k < 12 && k < total; k++) frame[k] = crc[8*(k-8) +: 8];
        if (kind == DG_BAD_MAGIC) begin
            k = $urandom_range(0, 3);
            frame[k] ^= 8'h1 << $urandom_range(0, 7);
        end
        foreach (frame[j]) push_byte(frame[j], j == frame.size() - 1);
    endtask

    function automatic int unsigned trailing_bytes();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    endfunction

    // mostly well-formed datagrams, the rest faults and noise
    task automatic send_random_datagram();
        int unsigned pick;
        int unsigned declared;
        pick = $urandom_range(0, 99);
        declared = ($urandom_range(0, 39) == 0) ? $urandom_range(41, 400) : $urandom_range(0, 40);
        if (pick < 55) begin
            send_datagram(DG_GOOD, declared, trailing_bytes(), $urandom, $urandom);
        end else if (pick < 65) begin
            send_datagram(DG_BAD_CRC, declared, trailing_bytes(), $urandom, $urandom);
        end else if (pick < 73) begin
            send_datagram(DG_SHORT, declared, $urandom_range(1, 19), $urandom, $urandom);
        end else if (pick < 80) begin
            send_datagram(DG_BAD_MAGIC, declared, trailing_bytes(), $urandom, $urandom);
        end else if (pick < 87) begin
            send_datagram(DG_BAD_VERSION, declared, trailing_bytes(), $urandom, $urandom);
        end else if (pick < 95) begin
            declared = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 65535)
                                                   : $urandom_range(5, 60);
            send_datagram(DG_TRUNCATED, declared,
                          $urandom_range(20, (declared + 15 < 80) ? declared + 15 : 80),
                          $urandom, $urandom);
        end else begin
            send_datagram(DG_NOISE, 0, $urandom_range(1, 48), $urandom, $urandom);
        end
    endtask

    task automatic run_traffic(input int unsigned budget, input int unsigned min_frames);
        int unsigned bytes0;
        int unsigned frames0;
        bytes0  = accepted_bytes;
        frames0 = board.frames_noted;
        while (accepted_bytes - bytes0 < budget || board.frames_noted - frames0 < min_frames)
            send_random_datagram();
    endtask

    // stop offering and wait until every verdict is back
    task automatic settle();
        i_valid <= 1'b0;
        while (board.due_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write of the expected version, then read it back
    task automatic write_version(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VERSION_ADDR;
        pwdata  <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cur_version        = v;
        board.want_version = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== v)
            board.report_mismatch($sformatf("version read back %h, wrote %h", prdata[15:0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases under the reset version
        send_datagram(DG_SHORT, 0, 1, 32'h0, 32'h0);
        send_datagram(DG_SHORT, 4, 19, '1, '1);
        send_datagram(DG_GOOD, 0, 0, 32'h0, 32'hFFFFFFFF);
        send_datagram(DG_GOOD, 4, 0, 32'hFFFFFFFF, 32'h0);
        send_datagram(DG_GOOD, 10, 5, $urandom, $urandom);
        send_datagram(DG_BAD_CRC, 8, 0, $urandom, $urandom);
        send_datagram(DG_BAD_MAGIC, 8, 0, $urandom, $urandom);
        send_datagram(DG_BAD_VERSION, 8, 0, $urandom, $urandom);
        send_datagram(DG_TRUNCATED, 65535, 24, $urandom, $urandom);
        send_datagram(DG_TRUNCATED, 5, 20, $urandom, $urandom);
        send_datagram(DG_NOISE, 0, 30, $urandom, $urandom);
        // oversize: exactly full, the final mark lands on a dropped byte
        send_datagram(DG_GOOD, 2032, 2, $urandom, $urandom);
        settle();

        // version extremes
        write_version(16'd0);
        send_datagram(DG_GOOD, 6, 0, $urandom, $urandom);
        run_traffic(40, 2);
        settle();
        write_version(16'hFFFF);
        send_datagram(DG_GOOD, 6, 0, $urandom, $urandom);
        run_traffic(40, 2);
        settle();

        // random version, long result hold-off, one full pause midway
        write_version(16'($urandom_range(0, 65535)));
        hold_request = 1'b1;
        run_traffic(80, 3);
        i_valid <= 1'b0;
        while (board.due_verdicts.size() != 0) @(posedge i_clk);
        run_traffic(80, 3);
        settle();
        repeat (END_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.due_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
